// ===== rtl/core/suffix_array_range_narrow_top_macros.svh =====
// Assertion helpers used by the checker of this block.
`ifndef SUFFIX_ARRAY_RANGE_NARROW_TOP_MACROS_SVH
`define SUFFIX_ARRAY_RANGE_NARROW_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SARN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sarn check failed");

// Next-cycle implication, checked out of reset.
`define SARN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sarn check failed");

`endif

// ===== rtl/core/sarn_pkg.sv =====
`default_nettype none
package sarn_pkg;

  localparam int CMD_W = 2;
  localparam int IDX_W = 16;
  localparam int LEN_W = 17;
  localparam int SYM_W = 8;

  localparam logic [CMD_W-1:0] CMD_LOAD_TEXT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_SA   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] address;
    logic [IDX_W-1:0] value;
    logic [IDX_W-1:0] range_start;
    logic [IDX_W-1:0] range_end;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] char_offset;
  } in_word_t;

  typedef struct packed {
    logic [LEN_W-1:0] out_start;
    logic [IDX_W-1:0] out_end;
    logic             is_empty;
  } out_word_t;

endpackage
`default_nettype wire

// ===== rtl/core/sarn_ifs.sv =====
`default_nettype none
interface sarn_in_if import sarn_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sarn_out_if import sarn_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sarn_cfg_if import sarn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sarn_ram.sv =====
`default_nettype none
module sarn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/suffix_array_range_narrow_top.sv =====
`default_nettype none
// Suffix-array range narrowing. Command words load the text store (symbol in the low
// SYMBOL_BITS of value) or the suffix store, one entry per word; a search word narrows
// an inclusive suffix-array range to the suffixes whose character at char_offset equals
// symbol, with a lower and then an upper binary search, and returns one result word
// (empty is start 1, end 0). Every probe is two dependent reads of single-read-port
// memories, suffix store then text store; a search makes at most about
// 2*log2(range) + 4 probes. One item is worked at a time; the result sits in an output
// register, so the next word is taken while it waits. Text reads at or past text_length
// read as symbol 0. Stores are not cleared by reset.
module suffix_array_range_narrow_top import sarn_pkg::*; #(
  parameter int STORE_DEPTH = 65536,
  parameter int SYMBOL_BITS = 8
) (
  input wire logic clk,
  input wire logic rst_n,
  sarn_in_if.sink    in_chan,
  sarn_out_if.source out_chan,
  sarn_cfg_if.sink   cfg_chan
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [24:0] DEPTH_W = 25'(STORE_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SA   = 2'd1;
  localparam logic [1:0] ST_TX   = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [2:0] K_FIRST  = 3'd0;
  localparam logic [2:0] K_LO_MID = 3'd1;
  localparam logic [2:0] K_LO_END = 3'd2;
  localparam logic [2:0] K_UP_CHK = 3'd3;
  localparam logic [2:0] K_UP_MID = 3'd4;
  localparam logic [2:0] K_UP_FIN = 3'd5;

  logic [1:0]       state_r, state_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic [IDX_W-1:0] s_r, s_nxt, e_r, e_nxt, m_r, m_nxt;
  logic [LEN_W-1:0] res_s_r, res_s_nxt;
  logic [IDX_W-1:0] res_e_r, res_e_nxt;
  logic [SYM_W-1:0] c_r;
  logic [IDX_W-1:0] off_r;
  logic [LEN_W-1:0] text_len_r;
  logic             sa_ok_r, tx_ok_r;
  logic             out_valid_r;
  out_word_t        out_r;

  logic [IDX_W-1:0]       sa_idx;
  logic [IDX_W-1:0]       sa_rdata;
  logic [SYMBOL_BITS-1:0] tx_rdata;
  logic [IDX_W-1:0]       sa_val;
  logic [LEN_W-1:0]       pos;
  logic                   pos_ok;
  logic [SYM_W-1:0]       sym;
  logic                   in_acc;
  logic                   addr_ok;
  logic                   out_free;

  function automatic logic below_depth(input logic [LEN_W-1:0] x);
    return {8'd0, x} < DEPTH_W;
  endfunction

  assign in_acc   = in_chan.valid && (state_r == ST_IDLE);
  assign addr_ok  = below_depth({1'b0, in_chan.data.address});
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  // suffix word read last cycle, then the text position it points at
  assign sa_val = sa_ok_r ? sa_rdata : '0;
  assign pos    = {1'b0, sa_val} + {1'b0, off_r};
  assign pos_ok = (pos < text_len_r) && below_depth(pos);
  assign sym    = tx_ok_r ? SYM_W'(tx_rdata) : '0;

  sarn_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(STORE_DEPTH)) u_text_ram (
    .clk   (clk),
    .we    (in_acc && (in_chan.data.command == CMD_LOAD_TEXT) && addr_ok),
    .waddr (AW'(in_chan.data.address)),
    .wdata (in_chan.data.value[SYMBOL_BITS-1:0]),
    .raddr (AW'(pos)),
    .rdata (tx_rdata)
  );

  sarn_ram #(.WIDTH(IDX_W), .DEPTH(STORE_DEPTH)) u_sa_ram (
    .clk   (clk),
    .we    (in_acc && (in_chan.data.command == CMD_LOAD_SA) && addr_ok),
    .waddr (AW'(in_chan.data.address)),
    .wdata (in_chan.data.value),
    .raddr (AW'(sa_idx)),
    .rdata (sa_rdata)
  );

  always_comb begin
    logic [IDX_W-1:0] s_v;
    logic [IDX_W-1:0] e_v;
    logic [LEN_W-1:0] sum_v;
    logic             go_lo;
    logic             go_up;
    logic             hit;
    state_nxt = state_r;
    kind_nxt  = kind_r;
    s_nxt     = s_r;
    e_nxt     = e_r;
    m_nxt     = m_r;
    res_s_nxt = res_s_r;
    res_e_nxt = res_e_r;
    sa_idx    = s_r;
    s_v       = s_r;
    e_v       = e_r;
    go_lo     = 1'b0;
    go_up     = 1'b0;
    hit       = (sym == c_r);
    sum_v     = '0;
    case (state_r)
      ST_IDLE: begin
        sa_idx = in_chan.data.range_start;
        if (in_acc && (in_chan.data.command == CMD_SEARCH)) begin
          s_nxt    = in_chan.data.range_start;
          e_nxt    = in_chan.data.range_end;
          kind_nxt = K_FIRST;
          if (in_chan.data.range_start > in_chan.data.range_end) begin
            res_s_nxt = LEN_W'(1);
            res_e_nxt = '0;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_SA;
          end
        end
      end
      ST_SA: begin
        if (kind_r == K_FIRST) begin
          // short first suffix bumps the start
          res_s_nxt = (pos >= text_len_r) ? ({1'b0, s_r} + LEN_W'(1)) : {1'b0, s_r};
          res_e_nxt = e_r;
        end
        state_nxt = ST_TX;
      end
      ST_TX: begin
        case (kind_r)
          K_FIRST: begin
            if (s_r == e_r) begin
              if (!hit) begin
                res_s_nxt = LEN_W'(1);
                res_e_nxt = '0;
              end
              state_nxt = ST_EMIT;
            end else if (!hit) begin
              go_lo = 1'b1;
            end else begin
              kind_nxt  = K_UP_CHK;
              sa_idx    = e_r;
              state_nxt = ST_SA;
            end
          end
          K_LO_MID: begin
            if (sym < c_r) begin
              s_v = m_r;
            end else begin
              e_v = m_r;
            end
            go_lo = 1'b1;
          end
          K_LO_END: begin
            if (hit) begin
              res_s_nxt = {1'b0, e_r};
              s_nxt     = e_r;
              e_nxt     = res_e_r;
              kind_nxt  = K_UP_CHK;
              sa_idx    = res_e_r;
              state_nxt = ST_SA;
            end else begin
              res_s_nxt = LEN_W'(1);
              res_e_nxt = '0;
              state_nxt = ST_EMIT;
            end
          end
          K_UP_CHK: begin
            if (hit) begin
              state_nxt = ST_EMIT;
            end else begin
              go_up = 1'b1;
            end
          end
          K_UP_MID: begin
            if (sym > c_r) begin
              e_v = m_r;
            end else begin
              s_v = m_r;
            end
            go_up = 1'b1;
          end
          K_UP_FIN: begin
            if (hit) begin
              res_e_nxt = s_r;
            end else begin
              res_s_nxt = LEN_W'(1);
              res_e_nxt = '0;
            end
            state_nxt = ST_EMIT;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
        // advance the bisection: next midpoint, or the closing probe
        if (go_lo || go_up) begin
          s_nxt     = s_v;
          e_nxt     = e_v;
          state_nxt = ST_SA;
          sum_v     = {1'b0, s_v} + {1'b0, e_v};
          if (({1'b0, s_v} + LEN_W'(1)) < {1'b0, e_v}) begin
            m_nxt    = sum_v[LEN_W-1:1];
            sa_idx   = sum_v[LEN_W-1:1];
            kind_nxt = go_lo ? K_LO_MID : K_UP_MID;
          end else begin
            sa_idx   = go_lo ? e_v : s_v;
            kind_nxt = go_lo ? K_LO_END : K_UP_FIN;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= K_FIRST;
      out_valid_r <= 1'b0;
      text_len_r  <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      if (cfg_chan.valid) begin
        text_len_r <= cfg_chan.data;
      end
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r     <= s_nxt;
    e_r     <= e_nxt;
    m_r     <= m_nxt;
    res_s_r <= res_s_nxt;
    res_e_r <= res_e_nxt;
    sa_ok_r <= below_depth({1'b0, sa_idx});
    tx_ok_r <= pos_ok;
    if (in_acc) begin
      c_r   <= in_chan.data.symbol;
      off_r <= in_chan.data.char_offset;
    end
    if (state_r == ST_EMIT && out_free) begin
      out_r.out_start <= res_s_r;
      out_r.out_end   <= res_e_r;
      out_r.is_empty  <= (res_s_r > {1'b0, res_e_r});
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sarn_chk.sv =====
`default_nettype none
`include "suffix_array_range_narrow_top_macros.svh"
module sarn_chk import sarn_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic [CMD_W-1:0] in_command,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [LEN_W-1:0] out_start,
  input wire logic [IDX_W-1:0] out_end,
  input wire logic             out_is_empty
);

  `SARN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_start) && $stable(out_end))
  `SARN_ASSERT_NOW(a_empty_flag, out_valid, out_is_empty == (out_start > {1'b0, out_end}))
  `SARN_ASSERT_NEXT(a_search_busy, in_valid && in_ready && (in_command == CMD_SEARCH), !in_ready)
  `SARN_ASSERT_NOW(a_reset_quiet, !$past(rst_n), !out_valid)

endmodule

bind suffix_array_range_narrow_top sarn_chk u_sarn_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_command   (in_chan.data.command),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_start    (out_chan.data.out_start),
  .out_end      (out_chan.data.out_end),
  .out_is_empty (out_chan.data.is_empty)
);
`default_nettype wire
